/* src/button_gesture_detector_macros.svh */
// Assertion helpers shared by the block's RTL.
`ifndef BUTTON_GESTURE_DETECTOR_MACROS_SVH
`define BUTTON_GESTURE_DETECTOR_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define BGD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is held.
`define BGD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/bgd_pkg.sv */
package bgd_pkg;

    localparam int NUM_BUTTONS_DEF = 16;
    localparam int APB_AW          = 5;
    localparam int TIME_W          = 32;
    localparam int CFG_W           = 16;

    // Event codes on the result channel
    typedef enum logic [2:0] {
        EV_PRESS   = 3'd0,
        EV_RELEASE = 3'd1,
        EV_LONG1   = 3'd2,
        EV_LONG2   = 3'd3,
        EV_LONG3   = 3'd4,
        EV_DOUBLE  = 3'd5,
        EV_SINGLE  = 3'd6
    } t_event_code;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        CFG_DEBOUNCE   = 3'd0,
        CFG_LONG_FIRST = 3'd1,
        CFG_LONG_SECOND = 3'd2,
        CFG_LONG_THIRD = 3'd3,
        CFG_CLICK_GAP  = 3'd4
    } t_cfg_reg;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;
    localparam logic [CFG_W-1:0] LONG_FIRST_RST  = 16'd2000;
    localparam logic [CFG_W-1:0] LONG_SECOND_RST = 16'd5000;
    localparam logic [CFG_W-1:0] LONG_THIRD_RST  = 16'd10000;
    localparam logic [CFG_W-1:0] CLICK_GAP_RST   = 16'd300;

    // Per-button state word held in the memory
    typedef struct packed {
        logic              stable_level;
        logic [TIME_W-1:0] change_time;
        logic [TIME_W-1:0] press_start;
        logic [1:0]        click_count;
        logic [TIME_W-1:0] click_time;
        logic [2:0]        long_flags;
    } t_entry;

    localparam t_entry ENTRY_RST = '{
        stable_level: 1'b1,
        change_time:  '0,
        press_start:  '0,
        click_count:  2'd0,
        click_time:   '0,
        long_flags:   3'd0
    };

endpackage

/* src/bgd_if.sv */
interface bgd_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  button_index;
    logic        pin_high;
    logic        pin_valid;
    logic [31:0] now_ms;

    modport source(output valid, button_index, pin_high, pin_valid, now_ms, input ready);
    modport sink(input valid, button_index, pin_high, pin_valid, now_ms, output ready);
endinterface

interface bgd_out_if;
    logic                  valid;
    logic                  ready;
    logic [3:0]            event_button;
    bgd_pkg::t_event_code  event_code;
    logic                  last_event;

    modport source(output valid, event_button, event_code, last_event, input ready);
    modport sink(input valid, event_button, event_code, last_event, output ready);
endinterface

/* src/button_gesture_detector.sv */
// Channel   Dir  Handshake        Payload
// i_in      in   valid/ready      button_index, pin_high, pin_valid, now_ms
// o_out     out  valid/ready      event_button, event_code, last_event
// APB       in   psel/penable     paddr[4:2] selects one of five 16-bit registers
//
// An accepted sample reads its button's state word through a registered memory read, and
// stage 1 then computes the events and writes the word back once it may advance: one new
// sample per cycle while the output keeps up.
// Each sample gives 0 to 3 events, which leave a 3-deep event holder one per cycle while the output is ready.
// Input stalls only while a sample with events waits for the holder to drain.
// Reset is synchronous; per-entry valid flops make unwritten entries read as reset.
module button_gesture_detector #(
    parameter int NUM_BUTTONS = bgd_pkg::NUM_BUTTONS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bgd_in_if.sink                     i_in,
    bgd_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bgd_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

`include "button_gesture_detector_macros.svh"

    localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int TW = bgd_pkg::TIME_W;
    localparam int CW = bgd_pkg::CFG_W;

    // Configuration registers
    logic [CW-1:0] r_debounce, r_long_first, r_long_second, r_long_third, r_click_gap;
    logic          cfg_we;
    bgd_pkg::t_cfg_reg cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = bgd_pkg::t_cfg_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce    <= bgd_pkg::DEBOUNCE_RST;
            r_long_first  <= bgd_pkg::LONG_FIRST_RST;
            r_long_second <= bgd_pkg::LONG_SECOND_RST;
            r_long_third  <= bgd_pkg::LONG_THIRD_RST;
            r_click_gap   <= bgd_pkg::CLICK_GAP_RST;
        end else if (cfg_we) begin
            case (cfg_idx)
                bgd_pkg::CFG_DEBOUNCE:    r_debounce    <= pwdata[CW-1:0];
                bgd_pkg::CFG_LONG_FIRST:  r_long_first  <= pwdata[CW-1:0];
                bgd_pkg::CFG_LONG_SECOND: r_long_second <= pwdata[CW-1:0];
                bgd_pkg::CFG_LONG_THIRD:  r_long_third  <= pwdata[CW-1:0];
                bgd_pkg::CFG_CLICK_GAP:   r_click_gap   <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (cfg_idx)
            bgd_pkg::CFG_DEBOUNCE:    prdata = 32'(r_debounce);
            bgd_pkg::CFG_LONG_FIRST:  prdata = 32'(r_long_first);
            bgd_pkg::CFG_LONG_SECOND: prdata = 32'(r_long_second);
            bgd_pkg::CFG_LONG_THIRD:  prdata = 32'(r_long_third);
            bgd_pkg::CFG_CLICK_GAP:   prdata = 32'(r_click_gap);
            default:                  prdata = 32'd0;
        endcase
    end

    // Handshake and stage control
    logic          in_acc, in_ok, s1_adv, s2_free, s2_load, out_pop;
    logic [AW-1:0] in_addr;
    logic [1:0]    ev_n;
    bgd_pkg::t_event_code ev_codes [3];

    logic          r_s1_valid;
    logic [AW-1:0] r_s1_addr;
    logic [3:0]    r_s1_button;
    logic          r_s1_level;
    logic [TW-1:0] r_s1_now;

    logic [1:0]           r_s2_cnt;
    logic [3:0]           r_s2_button;
    bgd_pkg::t_event_code r_s2_codes [3];

    assign in_addr  = AW'(i_in.button_index);
    assign in_ok    = i_in.pin_valid && (32'(i_in.button_index) < 32'(NUM_BUTTONS));
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_pop  = o_out.valid && o_out.ready;
    assign s2_free  = (r_s2_cnt == 2'd0) || ((r_s2_cnt == 2'd1) && out_pop);
    assign s1_adv   = r_s1_valid && ((ev_n == 2'd0) || s2_free);
    assign s2_load  = s1_adv && (ev_n != 2'd0);
    assign i_in.ready = !r_s1_valid || s1_adv;

    // State memory, valid flops and bypass of a same-button write
    bgd_pkg::t_entry mem [NUM_BUTTONS];
    bgd_pkg::t_entry r_rd_data, r_byp_data, cur, n_entry;
    logic [NUM_BUTTONS-1:0] r_vld;
    logic                   r_rd_vld, r_byp_hit;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            mem[r_s1_addr] <= n_entry;
        end
        if (in_acc) begin
            r_rd_data <= mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_byp_hit <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_vld[r_s1_addr] <= 1'b1;
            end
            if (in_acc) begin
                r_rd_vld  <= r_vld[in_addr];
                r_byp_hit <= s1_adv && (r_s1_addr == in_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byp_data <= n_entry;
        end
    end

    // Stage 1 item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid && in_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_addr   <= in_addr;
            r_s1_button <= i_in.button_index;
            r_s1_level  <= i_in.pin_high;
            r_s1_now    <= i_in.now_ms;
        end
    end

    // Pick current state word: bypass, memory, or reset value
    always_comb begin
        if (r_byp_hit) begin
            cur = r_byp_data;
        end else if (r_rd_vld) begin
            cur = r_rd_data;
        end else begin
            cur = bgd_pkg::ENTRY_RST;
        end
    end

    // Modify: debounce, click counting, long press and click timeout
    logic [TW-1:0] since_change, held, since_click;
    logic          l1, l2, l3;

    assign since_change = r_s1_now - cur.change_time;
    assign held         = r_s1_now - cur.press_start;
    assign since_click  = r_s1_now - cur.click_time;
    assign l1 = !cur.long_flags[0] && (held >= TW'(r_long_first));
    assign l2 = !cur.long_flags[1] && (held >= TW'(r_long_second));
    assign l3 = !cur.long_flags[2] && (held >= TW'(r_long_third));

    always_comb begin
        n_entry     = cur;
        ev_n        = 2'd0;
        ev_codes[0] = bgd_pkg::EV_PRESS;
        ev_codes[1] = bgd_pkg::EV_PRESS;
        ev_codes[2] = bgd_pkg::EV_PRESS;
        if (r_s1_level != cur.stable_level) begin
            if (since_change >= TW'(r_debounce)) begin
                n_entry.stable_level = r_s1_level;
                n_entry.change_time  = r_s1_now;
                ev_n = 2'd1;
                if (!r_s1_level) begin
                    n_entry.press_start = r_s1_now;
                    ev_codes[0] = bgd_pkg::EV_PRESS;
                end else begin
                    ev_codes[0] = bgd_pkg::EV_RELEASE;
                    if (held < TW'(r_long_first)) begin
                        if (cur.click_count != 2'd3) begin
                            n_entry.click_count = cur.click_count + 2'd1;
                        end
                        n_entry.click_time = r_s1_now;
                    end
                    n_entry.long_flags = 3'd0;
                end
            end
        end else if (!r_s1_level) begin
            // Report each newly reached threshold, packed in order
            if (l1) begin
                n_entry.long_flags[0] = 1'b1;
                ev_codes[ev_n] = bgd_pkg::EV_LONG1;
                ev_n = ev_n + 2'd1;
            end
            if (l2) begin
                n_entry.long_flags[1] = 1'b1;
                ev_codes[ev_n] = bgd_pkg::EV_LONG2;
                ev_n = ev_n + 2'd1;
            end
            if (l3) begin
                n_entry.long_flags[2] = 1'b1;
                ev_codes[ev_n] = bgd_pkg::EV_LONG3;
                ev_n = ev_n + 2'd1;
            end
        end else if ((cur.click_count != 2'd0) && (since_click >= TW'(r_click_gap))) begin
            if (cur.click_count == 2'd2) begin
                ev_n        = 2'd1;
                ev_codes[0] = bgd_pkg::EV_DOUBLE;
            end else if (cur.click_count == 2'd1) begin
                ev_n        = 2'd1;
                ev_codes[0] = bgd_pkg::EV_SINGLE;
            end
            n_entry.click_count = 2'd0;
        end
    end

    // Event holder: load a sample's events, shift one out per pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_cnt <= 2'd0;
        end else if (s2_load) begin
            r_s2_cnt <= ev_n;
        end else if (out_pop) begin
            r_s2_cnt <= r_s2_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_s2_button <= r_s1_button;
            r_s2_codes  <= ev_codes;
        end else if (out_pop) begin
            r_s2_codes[0] <= r_s2_codes[1];
            r_s2_codes[1] <= r_s2_codes[2];
        end
    end

    assign o_out.valid        = (r_s2_cnt != 2'd0);
    assign o_out.event_button = r_s2_button;
    assign o_out.event_code   = r_s2_codes[0];
    assign o_out.last_event   = (r_s2_cnt == 2'd1);

    // Checks
    `BGD_ASSERT_NOW(a_stall_cause, !i_in.ready, r_s1_valid && (r_s2_cnt != 2'd0), "input stalled without a blocked event")
    `BGD_ASSERT_NEXT(a_load_shows, s2_load, o_out.valid, "loaded events not presented")
    `BGD_ASSERT_NEXT(a_bypass_set, in_acc && s1_adv && (r_s1_addr == in_addr), r_byp_hit, "same-button write not forwarded")

endmodule
